@@ design/banked_register_file_access_defines.svh @@
// assertion macros for the banked register file access block
// needs clk and arst_n in the scope of every module that uses them
`ifndef BANKED_REGISTER_FILE_ACCESS_DEFINES_SVH
`define BANKED_REGISTER_FILE_ACCESS_DEFINES_SVH
`ifndef ASSERT_OFF
// checked outside reset
`define BRF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("brf assertion failed");
// checked at every edge, reset included
`define BRF_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("brf assertion failed during reset");
`else
`define BRF_ASSERT(lbl, prop)
`define BRF_ASSERT_RST(lbl, prop)
`endif
`endif

@@ design/brf_pkg.sv @@
// types and constants of the banked register file access block
// no dependencies
package brf_pkg;

	// register spaces
	localparam logic [2:0] SPACE_GENERAL = 3'd0;
	localparam logic [2:0] SPACE_CONTROL = 3'd1;
	localparam logic [2:0] SPACE_PC      = 3'd2;
	localparam logic [2:0] SPACE_ACC_LO  = 3'd3;
	localparam logic [2:0] SPACE_ACC_HI  = 3'd4;

	// control register numbers
	localparam logic [3:0] CTL_PSW   = 4'd0;
	localparam logic [3:0] CTL_CBR   = 4'd1;
	localparam logic [3:0] CTL_SPI   = 4'd2;
	localparam logic [3:0] CTL_SPU   = 4'd3;
	localparam logic [3:0] CTL_SPARE0 = 4'd4;
	localparam logic [3:0] CTL_SPARE1 = 4'd5;
	localparam logic [3:0] CTL_BPC   = 4'd6;

	// general register file
	localparam int GENERAL_COUNT = 16;
	localparam logic [3:0] SP_INDEX = 4'd15;

	// status bit positions in the packed status word
	localparam int ST_COND  = 0;
	localparam int ST_IE    = 1;
	localparam int ST_SM    = 2;
	localparam int ST_BCOND = 3;
	localparam int ST_BIE   = 4;
	localparam int ST_BSM   = 5;

	// matching bit positions in the psw
	localparam int PSW_COND  = 0;
	localparam int PSW_IE    = 6;
	localparam int PSW_SM    = 7;
	localparam int PSW_BCOND = 8;
	localparam int PSW_BIE   = 14;
	localparam int PSW_BSM   = 15;

	typedef enum logic {
		ACT_READ  = 1'b0,
		ACT_WRITE = 1'b1
	} action_t;

	typedef struct packed {
		action_t     action;
		logic [2:0]  reg_space;
		logic [3:0]  reg_index;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
	} rsp_t;

endpackage

@@ design/brf_req_if.sv @@
// access request channel of the banked register file
// depends on brf_pkg
interface brf_req_if;
	logic          valid;
	logic          ready;
	brf_pkg::req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ design/brf_rsp_if.sv @@
// read data channel of the banked register file
// depends on brf_pkg
interface brf_rsp_if;
	logic          valid;
	logic          ready;
	brf_pkg::rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ design/banked_register_file_access.sv @@
// banked register file with one access port: general, control, pc, accumulator
// depends on brf_pkg, brf_req_if, brf_rsp_if and the assertion macro header
//
// usage:
//   req carries one access beat (action, reg_space, reg_index, write_data).
//   rsp returns exactly one beat per request, in order: the register value on
//   a read, zero on a write.
//   a request beat lands in the stage 1 register; in the cycle it leaves,
//   the register state is read and updated, and the result goes to the
//   stage 2 output register. throughput: one access per cycle while
//   rsp does not stall, set by the read-modify-write of the register
//   state in stage 1.
//   when rsp stalls, the result holds in stage 2 and one more request waits
//   in stage 1; req.ready then drops until rsp takes its beat.
//   asynchronous reset (arst_n low) clears all registers, the accumulator,
//   the stack copies and the status bits, and empties both stages.
//   a psw write that flips the stack mode swaps general register 15 with the
//   saved copy of the other stack bank.
`include "banked_register_file_access_defines.svh"

module banked_register_file_access (
	input  logic      clk,
	input  logic      arst_n,
	brf_req_if.sink   req,
	brf_rsp_if.source rsp
);

	// stage registers
	brf_pkg::req_t req_s1;
	logic          valid_s1;
	logic [31:0]   read_data_s2;
	logic          valid_s2;

	// architectural state
	logic [31:0] gen_q [brf_pkg::GENERAL_COUNT];
	logic [31:0] pc_q;
	logic [63:0] acc_q;
	logic [31:0] spi_q;
	logic [31:0] spu_q;
	logic [31:0] spare0_q;
	logic [31:0] spare1_q;
	logic [31:0] bpc_q;
	logic [5:0]  status_q;

	logic        advance;
	logic        take;
	logic        is_write;
	logic        user_mode;
	logic [31:0] read_val;
	logic [31:0] psw_val;
	logic [5:0]  psw_next;

	// handshake
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign take      = req.valid && req.ready;
	assign is_write  = (req_s1.action == brf_pkg::ACT_WRITE);
	assign user_mode = status_q[brf_pkg::ST_SM];

	assign rsp.valid          = valid_s2;
	assign rsp.data.read_data = read_data_s2;

	// psw packing and unpacking
	always_comb begin
		psw_val = '0;
		psw_val[brf_pkg::PSW_BSM]   = status_q[brf_pkg::ST_BSM];
		psw_val[brf_pkg::PSW_BIE]   = status_q[brf_pkg::ST_BIE];
		psw_val[brf_pkg::PSW_BCOND] = status_q[brf_pkg::ST_BCOND];
		psw_val[brf_pkg::PSW_SM]    = status_q[brf_pkg::ST_SM];
		psw_val[brf_pkg::PSW_IE]    = status_q[brf_pkg::ST_IE];
		psw_val[brf_pkg::PSW_COND]  = status_q[brf_pkg::ST_COND];
		psw_next = '0;
		psw_next[brf_pkg::ST_BSM]   = req_s1.write_data[brf_pkg::PSW_BSM];
		psw_next[brf_pkg::ST_BIE]   = req_s1.write_data[brf_pkg::PSW_BIE];
		psw_next[brf_pkg::ST_BCOND] = req_s1.write_data[brf_pkg::PSW_BCOND];
		psw_next[brf_pkg::ST_SM]    = req_s1.write_data[brf_pkg::PSW_SM];
		psw_next[brf_pkg::ST_IE]    = req_s1.write_data[brf_pkg::PSW_IE];
		psw_next[brf_pkg::ST_COND]  = req_s1.write_data[brf_pkg::PSW_COND];
	end

	// read mux
	always_comb begin
		read_val = '0;
		case (req_s1.reg_space)
			brf_pkg::SPACE_GENERAL: read_val = gen_q[req_s1.reg_index];
			brf_pkg::SPACE_CONTROL: begin
				case (req_s1.reg_index)
					brf_pkg::CTL_PSW:    read_val = psw_val;
					brf_pkg::CTL_CBR:    read_val = {31'd0, status_q[brf_pkg::ST_COND]};
					brf_pkg::CTL_SPI:    read_val = user_mode ? spi_q : gen_q[brf_pkg::SP_INDEX];
					brf_pkg::CTL_SPU:    read_val = user_mode ? gen_q[brf_pkg::SP_INDEX] : spu_q;
					brf_pkg::CTL_SPARE0: read_val = spare0_q;
					brf_pkg::CTL_SPARE1: read_val = spare1_q;
					brf_pkg::CTL_BPC:    read_val = bpc_q;
					default:             read_val = '0;
				endcase
			end
			brf_pkg::SPACE_PC:     read_val = pc_q;
			brf_pkg::SPACE_ACC_LO: read_val = acc_q[31:0];
			brf_pkg::SPACE_ACC_HI: read_val = acc_q[63:32];
			default:               read_val = '0;
		endcase
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req.data;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// stage 2 result
	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_s2 <= is_write ? 32'd0 : read_val;
		end
	end

	// register state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < brf_pkg::GENERAL_COUNT; i++) begin
				gen_q[i] <= '0;
			end
			pc_q     <= '0;
			acc_q    <= '0;
			spi_q    <= '0;
			spu_q    <= '0;
			spare0_q <= '0;
			spare1_q <= '0;
			bpc_q    <= '0;
			status_q <= '0;
		end else if (advance && is_write) begin
			case (req_s1.reg_space)
				brf_pkg::SPACE_GENERAL: gen_q[req_s1.reg_index] <= req_s1.write_data;
				brf_pkg::SPACE_CONTROL: begin
					case (req_s1.reg_index)
						brf_pkg::CTL_PSW: begin
							status_q <= psw_next;
							// stack mode flip swaps the live sp with the other bank
							if (psw_next[brf_pkg::ST_SM] != user_mode) begin
								if (user_mode) begin
									spu_q <= gen_q[brf_pkg::SP_INDEX];
									gen_q[brf_pkg::SP_INDEX] <= spi_q;
								end else begin
									spi_q <= gen_q[brf_pkg::SP_INDEX];
									gen_q[brf_pkg::SP_INDEX] <= spu_q;
								end
							end
						end
						brf_pkg::CTL_CBR: status_q[brf_pkg::ST_COND] <= req_s1.write_data[0];
						brf_pkg::CTL_SPI: begin
							if (user_mode) begin
								spi_q <= req_s1.write_data;
							end else begin
								gen_q[brf_pkg::SP_INDEX] <= req_s1.write_data;
							end
						end
						brf_pkg::CTL_SPU: begin
							if (user_mode) begin
								gen_q[brf_pkg::SP_INDEX] <= req_s1.write_data;
							end else begin
								spu_q <= req_s1.write_data;
							end
						end
						brf_pkg::CTL_SPARE0: spare0_q <= req_s1.write_data;
						brf_pkg::CTL_SPARE1: spare1_q <= req_s1.write_data;
						brf_pkg::CTL_BPC:    bpc_q <= req_s1.write_data;
						default: ;
					endcase
				end
				brf_pkg::SPACE_PC:     pc_q <= req_s1.write_data;
				brf_pkg::SPACE_ACC_LO: acc_q[31:0] <= req_s1.write_data;
				brf_pkg::SPACE_ACC_HI: acc_q[63:32] <= req_s1.write_data;
				default: ;
			endcase
		end
	end

	// assertions
	`BRF_ASSERT_RST(a_reset_empty, !arst_n |-> !valid_s2)
	`BRF_ASSERT(a_write_reads_zero, (advance && is_write) |=> (read_data_s2 == 32'd0))
	`BRF_ASSERT(a_result_from_stage1, $rose(valid_s2) |-> $past(advance))
	`BRF_ASSERT(a_swap_to_user,
		(advance && is_write && req_s1.reg_space == brf_pkg::SPACE_CONTROL &&
		req_s1.reg_index == brf_pkg::CTL_PSW && !user_mode && psw_next[brf_pkg::ST_SM])
		|=> (gen_q[brf_pkg::SP_INDEX] == $past(spu_q) && spi_q == $past(gen_q[brf_pkg::SP_INDEX])))

endmodule
